>>> design/sit_pkg.sv
// Shared constants, types and helpers of the sorted insert table.
`default_nettype none
package sit_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic [0:0] REG_ORDER = 1'b0;

  typedef struct packed {
    logic en;
    idx_t addr;
    key_t data;
  } ram_wr_t;

  // True when a stored entry sits in front of the key being placed.
  function automatic logic goes_before(key_t entry, key_t key, logic ascending);
    goes_before = ascending ? (entry <= key) : (key <= entry);
  endfunction

endpackage
`default_nettype wire

>>> design/sit_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none
module sit_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> design/sit_apb_regs.sv
// APB configuration register holding the sort order.
`default_nettype none
module sit_apb_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic             ascending_order
);
  import sit_pkg::*;

  logic wr_xfer;

  assign pready  = 1'b1;
  assign wr_xfer = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascending_order <= 1'b1;
    end else if (wr_xfer && paddr[2] == REG_ORDER) begin
      ascending_order <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ORDER) begin
      prdata[0] = ascending_order;
    end
  end

endmodule
`default_nettype wire

>>> design/sit_seq.sv
// Sequencer that scans, shifts and places entries through the table RAM.
`default_nettype none
module sit_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ascending_order,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic signed [31:0] key_value,
  input  wire logic [4:0]        read_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [5:0]             position,
  output logic [5:0]             entry_count,
  output logic signed [31:0]     read_value,
  output logic [1:0]             status,
  output sit_pkg::idx_t          rd_addr,
  input  wire sit_pkg::key_t     rd_data,
  output sit_pkg::ram_wr_t       ram_wr
);
  import sit_pkg::*;

  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_RDWAIT,
    S_FINISH
  } state_t;

  state_t  state;
  cnt_t    count;
  cnt_t    pos;
  cnt_t    wr_tgt;
  key_t    key;
  cnt_t    res_pos;
  key_t    res_val;
  status_t res_status;
  cnt_t    pos_inc;
  logic    hit_before;
  logic    ridx_ok;

  assign in_ready   = (state == S_IDLE);
  assign pos_inc    = pos + cnt_t'(1);
  assign hit_before = goes_before(rd_data, key, ascending_order);
  assign ridx_ok    = CMP_W'(read_index) < CMP_W'(count);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (action == ACT_READ) ? idx_t'(read_index) : '0;
      S_SCAN:  rd_addr = hit_before ? idx_t'(pos_inc) : idx_t'(count - cnt_t'(1));
      S_SHIFT: rd_addr = idx_t'(wr_tgt - cnt_t'(2));
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_SHIFT: ram_wr = '{en: 1'b1, addr: idx_t'(wr_tgt), data: rd_data};
      S_PLACE: ram_wr = '{en: 1'b1, addr: idx_t'(pos), data: key};
      default: ram_wr = '{en: 1'b0, addr: '0, data: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_pos    <= '0;
            res_val    <= '0;
            res_status <= ST_OK;
            key        <= key_value;
            pos        <= '0;
            case (action)
              ACT_INSERT: begin
                if (count == cnt_t'(TABLE_DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_FINISH;
                end else if (count == '0) begin
                  state <= S_PLACE;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_READ: begin
                if (ridx_ok) begin
                  state <= S_RDWAIT;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_FINISH;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (hit_before) begin
            pos <= pos_inc;
            if (pos_inc == count) begin
              state <= S_PLACE;
            end
          end else begin
            wr_tgt <= count;
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          wr_tgt <= wr_tgt - cnt_t'(1);
          if (wr_tgt == pos_inc) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          count   <= count + cnt_t'(1);
          res_pos <= pos;
          state   <= S_FINISH;
        end
        S_RDWAIT: begin
          res_val <= rd_data;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            position    <= 6'(res_pos);
            entry_count <= 6'(count);
            read_value  <= res_val;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/sorted_insert_table_core.sv
// Top level of the sorted insert table: configuration port, sequencer and table RAM.
// Clear, a dropped insert and an out-of-range read go straight to the result, and a
// read first waits for the registered RAM read. An insert at position p into a table
// of n entries takes p + 1 scan reads, n - p shift steps and one placement when p < n;
// when the key goes last there are no shift steps. The result is issued once the output is free.
// One item is worked at a time; the single read port of the table RAM sets the pace.
// Reset empties the table and selects ascending order; the RAM contents are not cleared.
`default_nettype none
module sorted_insert_table_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic signed [31:0] key_value,
  input  wire logic [4:0]        read_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [5:0]             position,
  output logic [5:0]             entry_count,
  output logic signed [31:0]     read_value,
  output logic [1:0]             status
);
  import sit_pkg::*;

  logic    ascending_order;
  idx_t    rd_addr;
  key_t    rd_data;
  ram_wr_t ram_wr;

  sit_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ascending_order (ascending_order)
  );

  sit_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .ascending_order (ascending_order),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .key_value       (key_value),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .position        (position),
    .entry_count     (entry_count),
    .read_value      (read_value),
    .status          (status),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .ram_wr          (ram_wr)
  );

  sit_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire
